@@ design/spba_pkg.sv @@
// Package for the shared palette bank allocator.
// Holds field widths, status codes, default sizes and the item-to-sheet table.
// No dependencies.
`default_nettype none

package spba_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int DEF_NUM_LAYERS = 16;
   localparam int DEF_FIRST_BANK = 8;
   localparam int DEF_NUM_BANKS  = 8;
   localparam int DEF_NUM_SHEETS = 32;

   // Fixed field widths
   localparam int ID_W     = 6;
   localparam int LAYER_W  = 4;
   localparam int BANK_W   = 4;
   localparam int SHEET_W  = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int MAPB_W   = 5;   // stored absolute bank, up to FIRST_BANK + NUM_BANKS - 1
   localparam int SEARCH_W = 16;  // width of the shared first-set search

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // Operation codes
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_LAYER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_BANK  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_ID   = 2'd3;

   // Item id to sheet table; ids at or above ITEM_COUNT are rejected
   localparam int ITEM_COUNT = 53;
   localparam logic [SHEET_W-1:0] ITEM_SHEET [ITEM_COUNT] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd1, 5'd1,
      5'd2, 5'd2,
      5'd3, 5'd3, 5'd3, 5'd3, 5'd3,
      5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
      5'd5, 5'd5, 5'd5, 5'd5,
      5'd6, 5'd6, 5'd6, 5'd6,
      5'd7, 5'd7,
      5'd8, 5'd8,
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
   };

endpackage

`default_nettype wire

@@ design/spba_find.sv @@
// Shared first-set search unit of the palette bank allocator.
// Used once for the lowest free layer and once for the lowest idle bank.
// Depends on spba_pkg.
`default_nettype none

module spba_find
   import spba_pkg::*;
(
   input  wire logic [SEARCH_W-1:0] vec,
   output logic      [LAYER_W-1:0]  idx,
   output logic                     hit
);

   // Scan from the top so the lowest set bit wins
   always_comb begin
      idx = '0;
      hit = 1'b0;
      for (int i = SEARCH_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = LAYER_W'(i);
            hit = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/shared_palette_bank_allocator_core.sv @@
// Top level of the shared palette bank allocator: handshake, sequencer,
// layer/bank state, sheet map memory and result register.
// Depends on spba_pkg and spba_find.
//
//   Channel  Direction  Beat contents
//   req_*    in         tuser: operation; tdata: item_id, release_layer,
//                       release_bank, bank_present
//   rsp_*    out        tuser: status; tdata: layer, bank, load_palette, sheet
//
// An acquire passes through accept (sheet lookup and map memory read),
// free-layer search, idle-bank search and commit. Both searches go through the
// one shared search unit. Release and bad-id beats skip the searches and go
// from accept straight to commit.
// Reset frees all layers, zeroes the bank user counts and invalidates the map.
// Commit waits while the result register holds a beat not yet taken; a new
// request is taken while the previous result is still waiting.
`default_nettype none

module shared_palette_bank_allocator_core
   import spba_pkg::*;
#(
   parameter int NUM_LAYERS = DEF_NUM_LAYERS,
   parameter int FIRST_BANK = DEF_FIRST_BANK,
   parameter int NUM_BANKS  = DEF_NUM_BANKS,
   parameter int NUM_SHEETS = DEF_NUM_SHEETS
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [5:0] item_id, [9:6] release_layer,
                                         // [13:10] release_bank, [14] bank_present
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [3:0] layer, [7:4] bank, [8] load_palette,
                                         // [13:9] sheet
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
   localparam int KW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int SW = $clog2(NUM_SHEETS);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LAYER  = 5'b00010,
      S_BANK   = 5'b00100,
      S_COMMIT = 5'b01000,
      S_SPARE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Captured request
   logic               op_ff;
   logic               bad_ff;
   logic [SHEET_W-1:0] sheet_ff;
   logic [LAYER_W-1:0] rlayer_ff;
   logic [BANK_W-1:0]  rbank_ff;
   logic               present_ff;

   // Allocator state
   logic [NUM_LAYERS-1:0] layer_in_use_ff;
   logic [COUNT_W-1:0]    count_ff [NUM_BANKS];
   logic [NUM_SHEETS-1:0] map_valid_ff;
   logic [MAPB_W-1:0]     map_mem [NUM_SHEETS];
   logic [MAPB_W-1:0]     map_rd_ff;

   // Search results
   logic [LAYER_W-1:0] layer_ff;
   logic               layer_hit_ff;
   logic [LAYER_W-1:0] bidx_ff;
   logic               bank_hit_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_user_ff, rsp_user_in;

   logic               accept;
   logic               out_free;
   logic               commit;
   logic [ID_W-1:0]    req_id;
   logic               req_bad;
   logic [SHEET_W-1:0] req_sheet;

   logic [SEARCH_W-1:0] free_vec;
   logic [SEARCH_W-1:0] idle_vec;
   logic [SEARCH_W-1:0] find_vec;
   logic [LAYER_W-1:0]  find_idx;
   logic                find_hit;

   logic [SW-1:0]      sheet_addr;
   logic               map_hit;
   logic [MAPB_W-1:0]  new_bank;
   logic [MAPB_W-1:0]  upd_bank;
   logic [5:0]         upd_off;
   logic               upd_in_range;
   logic [KW-1:0]      upd_k;
   logic [COUNT_W-1:0] cnt_cur;
   logic [COUNT_W-1:0] cnt_next;
   logic               cnt_inc;
   logic               cnt_en;
   logic               layer_set;
   logic               layer_clr;
   logic               map_set;
   logic               map_clr;
   logic [STATUS_W-1:0] r_status;
   logic [LAYER_W-1:0]  r_layer;
   logic [BANK_W-1:0]   r_bank;
   logic                r_load;
   logic [SHEET_W-1:0]  r_sheet;

   // Handshake
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_COMMIT) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Map the incoming id to its sheet
   assign req_id  = req_tdata[5:0];
   assign req_bad = (req_id >= ID_W'(ITEM_COUNT));
   always_comb begin
      req_sheet = '0;
      if (!req_bad) begin
         req_sheet = ITEM_SHEET[req_id];
      end
   end

   // Build the search vectors, then share one search unit between the layer and bank search states
   always_comb begin
      free_vec = '0;
      idle_vec = '0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
         free_vec[i] = !layer_in_use_ff[i];
      end
      for (int i = 0; i < NUM_BANKS; i++) begin
         idle_vec[i] = (count_ff[i] == '0);
      end
   end

   assign find_vec = (state_ff == S_LAYER) ? free_vec : idle_vec;

   spba_find u_find (
      .vec (find_vec),
      .idx (find_idx),
      .hit (find_hit)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == OP_ACQUIRE && !req_bad) ? S_LAYER : S_COMMIT;
            end
         end
         S_LAYER: begin
            state_in = S_BANK;
         end
         S_BANK: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Commit decision
   assign sheet_addr = SW'(sheet_ff);
   assign map_hit    = map_valid_ff[sheet_addr];
   assign new_bank   = MAPB_W'(bidx_ff) + MAPB_W'(FIRST_BANK);

   always_comb begin
      r_status  = ST_OK;
      r_layer   = '0;
      r_bank    = '0;
      r_load    = 1'b0;
      r_sheet   = sheet_ff;
      layer_set = 1'b0;
      layer_clr = 1'b0;
      map_set   = 1'b0;
      map_clr   = 1'b0;
      cnt_en    = 1'b0;
      cnt_inc   = 1'b0;
      upd_bank  = {1'b0, rbank_ff};
      if (bad_ff) begin
         r_status = ST_BAD_ID;
         r_sheet  = '0;
      end else if (op_ff == OP_ACQUIRE) begin
         if (!layer_hit_ff) begin
            r_status = ST_NO_LAYER;
         end else if (!map_hit && !bank_hit_ff) begin
            r_status = ST_NO_BANK;
         end else begin
            upd_bank  = map_hit ? map_rd_ff : new_bank;
            map_set   = !map_hit;
            r_load    = !map_hit;
            r_layer   = layer_ff;
            r_bank    = upd_bank[BANK_W-1:0];
            layer_set = 1'b1;
            cnt_inc   = 1'b1;
            cnt_en    = upd_in_range;
         end
      end else begin
         layer_clr = ({1'b0, rlayer_ff} < (LAYER_W + 1)'(NUM_LAYERS));
         if (present_ff) begin
            cnt_en  = upd_in_range;
            map_clr = !upd_in_range || (cnt_next == '0);
         end
      end
   end

   // Saturating count step on the selected bank
   assign upd_off      = 6'(upd_bank) - 6'(FIRST_BANK);
   assign upd_in_range = (6'(upd_bank) >= 6'(FIRST_BANK)) && (upd_off < 6'(NUM_BANKS));
   assign upd_k        = upd_off[KW-1:0];
   assign cnt_cur      = count_ff[upd_k];

   always_comb begin
      cnt_next = cnt_cur;
      if (cnt_inc) begin
         if (cnt_cur != COUNT_MAX) begin
            cnt_next = cnt_cur + COUNT_W'(1);
         end
      end else if (cnt_cur != '0) begin
         cnt_next = cnt_cur - COUNT_W'(1);
      end
   end

   assign rsp_user_in = r_status;
   assign rsp_data_in = {2'b00, r_sheet, r_load, r_bank, r_layer};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         layer_in_use_ff <= '0;
         map_valid_ff    <= '0;
         for (int i = 0; i < NUM_BANKS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit) begin
            if (layer_set) begin
               layer_in_use_ff[layer_ff[LW-1:0]] <= 1'b1;
            end
            if (layer_clr) begin
               layer_in_use_ff[rlayer_ff[LW-1:0]] <= 1'b0;
            end
            if (map_set) begin
               map_valid_ff[sheet_addr] <= 1'b1;
            end
            if (map_clr) begin
               map_valid_ff[sheet_addr] <= 1'b0;
            end
            if (cnt_en) begin
               count_ff[upd_k] <= cnt_next;
            end
         end
      end
   end

   // Capture the request beat and read the sheet map
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_tuser;
         bad_ff     <= req_bad;
         sheet_ff   <= req_sheet;
         rlayer_ff  <= req_tdata[9:6];
         rbank_ff   <= req_tdata[13:10];
         present_ff <= req_tdata[14];
         map_rd_ff  <= map_mem[SW'(req_sheet)];
      end
   end

   // Write a newly assigned bank into the sheet map
   always_ff @(posedge clock) begin
      if (commit && map_set) begin
         map_mem[sheet_addr] <= upd_bank;
      end
   end

   // Hold search results
   always_ff @(posedge clock) begin
      if (state_ff == S_LAYER) begin
         layer_ff     <= find_idx;
         layer_hit_ff <= find_hit;
      end
      if (state_ff == S_BANK) begin
         bidx_ff     <= find_idx;
         bank_hit_ff <= find_hit;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

endmodule

`default_nettype wire
